FILE: rtl/core/kvt_pkg.sv
// Package for the linear key-value table: action codes, status codes and
// default sizes. Used by kvt_seq and the top level; depends on nothing.
`default_nettype none

package kvt_pkg;

  localparam int unsigned DefCapacity   = 64;
  localparam int unsigned DefKeyWidth   = 32;
  localparam int unsigned DefValueWidth = 32;

  // Fixed widths of the request and response ports.
  localparam int unsigned ActionWidth = 3;
  localparam int unsigned KeyPortW    = 32;
  localparam int unsigned ValuePortW  = 32;
  localparam int unsigned CountPortW  = 7;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [ActionWidth-1:0] {
    ACT_LOOKUP = 3'd0,
    ACT_ACCESS = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [StatusWidth-1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

endpackage

`default_nettype wire

FILE: rtl/core/kvt_ram.sv
// Entry memory of the key-value table: one write port and one read port
// with registered read data. Depends on nothing.
`default_nettype none

module kvt_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output      logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/kvt_seq.sv
// Sequencer of the key-value table: linear scan with one shared key
// comparator, action handling, compaction after a remove, result register.
// Depends on kvt_pkg; drives the ports of kvt_ram.
`default_nettype none

module kvt_seq #(
  parameter int unsigned Capacity = kvt_pkg::DefCapacity,
  parameter int unsigned KeyW     = kvt_pkg::DefKeyWidth,
  parameter int unsigned ValW     = kvt_pkg::DefValueWidth,
  parameter int unsigned AddrW    = 6,
  parameter int unsigned CntW     = 7
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic [kvt_pkg::ActionWidth-1:0]    action_i,
  input  wire logic [KeyW-1:0]                    key_i,
  input  wire logic [ValW-1:0]                    value_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic [ValW-1:0]                    value_o,
  output      logic                               found_o,
  output      logic [CntW-1:0]                    count_o,
  output      logic [kvt_pkg::StatusWidth-1:0]    status_o,
  output      logic                               wr_en_o,
  output      logic [AddrW-1:0]                   wr_addr_o,
  output      logic [KeyW+ValW-1:0]               wr_data_o,
  output      logic                               rd_en_o,
  output      logic [AddrW-1:0]                   rd_addr_o,
  input  wire logic [KeyW+ValW-1:0]               rd_data_i
);
  import kvt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic [ActionWidth-1:0] act_q;
  logic [KeyW-1:0]        key_q;
  logic [ValW-1:0]        val_q;
  logic [CntW-1:0]        fill_q;
  logic [CntW-1:0]        iss_q;
  logic [CntW-1:0]        pidx_q;
  logic                   pend_q;
  logic                   hit_q;
  logic [CntW-1:0]        pos_q;
  logic [ValW-1:0]        hval_q;
  logic [ValW-1:0]        res_val_q;
  logic [StatusWidth-1:0] res_stat_q;
  logic                   wr_en_q;
  logic [AddrW-1:0]       wr_addr_q;
  logic [KeyW+ValW-1:0]   wr_data_q;
  logic                   out_valid_q;
  logic [ValW-1:0]        out_val_q;
  logic                   out_found_q;
  logic [CntW-1:0]        out_cnt_q;
  logic [StatusWidth-1:0] out_stat_q;

  logic                   in_fire;
  logic                   issue;
  logic                   last_pend;
  logic                   key_match;
  logic                   full;
  logic [CntW-1:0]        prev_idx;
  logic [CntW-1:0]        next_pos;
  logic [KeyW-1:0]        rd_key;
  logic [ValW-1:0]        rd_val;
  logic [ValW-1:0]        ins_val;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // One read is issued per cycle while scanning or compacting; the data
  // comes back in the next cycle and is checked against the pending index.
  assign issue     = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (iss_q < fill_q);
  assign rd_en_o   = issue;
  assign rd_addr_o = iss_q[AddrW-1:0];

  assign rd_key    = rd_data_i[KeyW+ValW-1:ValW];
  assign rd_val    = rd_data_i[ValW-1:0];
  assign key_match = (rd_key == key_q);
  assign last_pend = (pidx_q + CntW'(1)) == fill_q;
  assign full      = (fill_q == CntW'(Capacity));
  assign prev_idx  = pidx_q - CntW'(1);
  assign next_pos  = pos_q + CntW'(1);
  assign ins_val   = (act_q == ACT_WRITE) ? val_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= '0;
      key_q       <= '0;
      val_q       <= '0;
      fill_q      <= '0;
      iss_q       <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      pos_q       <= '0;
      hval_q      <= '0;
      res_val_q   <= '0;
      res_stat_q  <= STAT_OK;
      wr_en_q     <= 1'b0;
      wr_addr_q   <= '0;
      wr_data_q   <= '0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_found_q <= 1'b0;
      out_cnt_q   <= '0;
      out_stat_q  <= STAT_OK;
    end else begin
      wr_en_q <= 1'b0;
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (issue) begin
        iss_q <= iss_q + CntW'(1);
      end
      pend_q <= issue;
      pidx_q <= iss_q;

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            act_q  <= action_i;
            key_q  <= key_i;
            val_q  <= value_i;
            iss_q  <= '0;
            pend_q <= 1'b0;
            hit_q  <= 1'b0;
            // An empty table needs no scan.
            state_q <= (fill_q == '0) ? S_ACT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (pend_q) begin
            if (key_match) begin
              hit_q   <= 1'b1;
              pos_q   <= pidx_q;
              hval_q  <= rd_val;
              state_q <= S_ACT;
            end else if (last_pend) begin
              hit_q   <= 1'b0;
              state_q <= S_ACT;
            end
          end
        end
        S_ACT: begin
          res_val_q  <= '0;
          res_stat_q <= STAT_OK;
          state_q    <= S_DONE;
          case (act_q)
            ACT_ACCESS, ACT_WRITE: begin
              if (hit_q) begin
                if (act_q == ACT_WRITE) begin
                  wr_en_q   <= 1'b1;
                  wr_addr_q <= pos_q[AddrW-1:0];
                  wr_data_q <= {key_q, val_q};
                  res_val_q <= val_q;
                end else begin
                  res_val_q <= hval_q;
                end
              end else if (full) begin
                res_stat_q <= STAT_FULL;
              end else begin
                wr_en_q   <= 1'b1;
                wr_addr_q <= fill_q[AddrW-1:0];
                wr_data_q <= {key_q, ins_val};
                res_val_q <= ins_val;
                fill_q    <= fill_q + CntW'(1);
              end
            end
            ACT_REMOVE: begin
              if (!hit_q) begin
                res_stat_q <= STAT_MISSING;
              end else if (next_pos == fill_q) begin
                fill_q <= fill_q - CntW'(1);
              end else begin
                // Move every later entry down by one place.
                iss_q   <= next_pos;
                pend_q  <= 1'b0;
                state_q <= S_SHIFT;
              end
            end
            ACT_CLEAR: begin
              fill_q <= '0;
            end
            default: begin
              res_val_q <= hit_q ? hval_q : '0;
            end
          endcase
        end
        S_SHIFT: begin
          if (pend_q) begin
            wr_en_q   <= 1'b1;
            wr_addr_q <= prev_idx[AddrW-1:0];
            wr_data_q <= rd_data_i;
            if (last_pend) begin
              fill_q  <= fill_q - CntW'(1);
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_found_q <= hit_q;
            out_cnt_q   <= fill_q;
            out_stat_q  <= res_stat_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_val_q;
  assign found_o     = out_found_q;
  assign count_o     = out_cnt_q;
  assign status_o    = out_stat_q;
  assign wr_en_o     = wr_en_q;
  assign wr_addr_o   = wr_addr_q;
  assign wr_data_o   = wr_data_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(Capacity))
    else $error("entry count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("new transaction accepted while a request is in work");

  a_write_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_q |-> (CntW'(wr_addr_q) < fill_q))
    else $error("memory write outside the occupied entries");

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_stat_q == STAT_FULL)) |-> !out_found_q)
    else $error("full status reported for a present key");

  a_missing_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ACT) && (act_q == ACT_REMOVE) && !hit_q) |=> $stable(fill_q))
    else $error("remove of an absent key changed the entry count");

endmodule

`default_nettype wire

FILE: rtl/core/linear_key_value_table_unit.sv
// Linear key-value table, top level; depends on kvt_pkg, kvt_ram and kvt_seq.
// A request scans the occupied entries one per cycle through one memory read port and one
// key comparator, stopping at the first match. The next transaction is accepted only once
// the result has been loaded into the output register. A remove of a present key that is
// not the last entry first compacts the later entries.
// Reset empties the table at once; entry contents stay undefined until written.
`default_nettype none

module linear_key_value_table_unit #(
  parameter int unsigned CAPACITY    = kvt_pkg::DefCapacity,
  parameter int unsigned KEY_WIDTH   = kvt_pkg::DefKeyWidth,
  parameter int unsigned VALUE_WIDTH = kvt_pkg::DefValueWidth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic [kvt_pkg::ActionWidth-1:0]    action_i,
  input  wire logic [kvt_pkg::KeyPortW-1:0]       key_i,
  input  wire logic [kvt_pkg::ValuePortW-1:0]     new_value_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic [kvt_pkg::ValuePortW-1:0]     read_value_o,
  output      logic                               found_o,
  output      logic [kvt_pkg::CountPortW-1:0]     entry_count_o,
  output      logic [kvt_pkg::StatusWidth-1:0]    status_o
);
  import kvt_pkg::*;

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned EntW  = KEY_WIDTH + VALUE_WIDTH;

  logic [KEY_WIDTH+KeyPortW-1:0]     key_ext;
  logic [VALUE_WIDTH+ValuePortW-1:0] val_ext;
  logic [KEY_WIDTH-1:0]              key_m;
  logic [VALUE_WIDTH-1:0]            val_m;
  logic [VALUE_WIDTH-1:0]            res_val;
  logic [CntW-1:0]                   res_cnt;
  logic [ValuePortW+VALUE_WIDTH-1:0] res_val_ext;
  logic [CountPortW+CntW-1:0]        res_cnt_ext;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [EntW-1:0]  wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [EntW-1:0]  rd_data;

  // Only the low KEY_WIDTH and VALUE_WIDTH bits of a request take part.
  assign key_ext = {{KEY_WIDTH{1'b0}}, key_i};
  assign val_ext = {{VALUE_WIDTH{1'b0}}, new_value_i};
  assign key_m   = key_ext[KEY_WIDTH-1:0];
  assign val_m   = val_ext[VALUE_WIDTH-1:0];

  kvt_ram #(
    .Depth (CAPACITY),
    .Width (EntW),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  kvt_seq #(
    .Capacity (CAPACITY),
    .KeyW     (KEY_WIDTH),
    .ValW     (VALUE_WIDTH),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .key_i       (key_m),
    .value_i     (val_m),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (res_val),
    .found_o     (found_o),
    .count_o     (res_cnt),
    .status_o    (status_o),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  assign res_val_ext   = {{ValuePortW{1'b0}}, res_val};
  assign res_cnt_ext   = {{CountPortW{1'b0}}, res_cnt};
  assign read_value_o  = res_val_ext[ValuePortW-1:0];
  assign entry_count_o = res_cnt_ext[CountPortW-1:0];

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for linear_key_value_table_unit: directed table walk,
// then episodes of random requests over key pools, checked against an in-bench
// table predictor. Depends on kvt_pkg and the table RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kvt_pkg::*;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned Capacity     = DefCapacity;
  localparam int unsigned DrainCycles  = 2 * Capacity + 8;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned ItemsTotal   = 1100;
  localparam int unsigned TimeoutNs    = 800_000 * ClkPeriod;
  localparam int unsigned NumDirRows   = 28;

  typedef struct packed {
    logic [ValuePortW-1:0] read_value;
    logic                  found;
    logic [CountPortW-1:0] entry_count;
    status_e               status;
  } kv_result_t;

  typedef struct packed {
    logic [ActionWidth-1:0] act;
    logic [KeyPortW-1:0]    key;
    logic [ValuePortW-1:0]  value;
    logic [7:0]             reps;
    logic                   typed;
    kv_result_t             want;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   req_valid  = 1'b0;
  logic [ActionWidth-1:0] req_action = '0;
  logic [KeyPortW-1:0]    req_key    = '0;
  logic [ValuePortW-1:0]  req_value  = '0;
  logic                   rsp_ready  = 1'b0;

  logic                   req_ready;
  logic                   rsp_valid;
  logic [ValuePortW-1:0]  rsp_value;
  logic                   rsp_found;
  logic [CountPortW-1:0]  rsp_count;
  logic [StatusWidth-1:0] rsp_status;

  // Shadow copy of the table, updated in transaction order.
  logic [KeyPortW-1:0]   tbl_keys [Capacity];
  logic [ValuePortW-1:0] tbl_vals [Capacity];
  int unsigned           tbl_fill = 0;

  kv_result_t  pending_results [$];
  int unsigned requests_sent  = 0;
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  bit          rx_hold_req    = 1'b0;

  // Expected values are typed in only where they follow directly from the
  // sequence; the rest come from the predictor.
  dir_row_t dir_rows [NumDirRows] = '{
    '{ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'd1, 1'b1, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b1,
      '{32'h0, 1'b0, 7'd0, STAT_MISSING}},
    '{ACT_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF, 8'd1, 1'b1, '{32'h0, 1'b0, 7'd1, STAT_OK}},
    '{ACT_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b1,
      '{32'hFFFF_FFFF, 1'b0, 7'd2, STAT_OK}},
    '{ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'd1, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, 7'd2, STAT_OK}},
    '{ACT_WRITE,  32'h0000_0000, 32'hA5A5_A5A5, 8'd1, 1'b1,
      '{32'hA5A5_A5A5, 1'b1, 7'd2, STAT_OK}},
    '{ACT_ACCESS, 32'h0000_0000, 32'h0000_0000, 8'd1, 1'b1,
      '{32'hA5A5_A5A5, 1'b1, 7'd2, STAT_OK}},
    '{ACT_WRITE,  32'h1234_5678, 32'h5A5A_5A5A, 8'd1, 1'b1,
      '{32'h5A5A_5A5A, 1'b0, 7'd3, STAT_OK}},
    '{ACT_REMOVE, 32'h0000_0000, 32'h0000_0000, 8'd1, 1'b1, '{32'h0, 1'b1, 7'd2, STAT_OK}},
    '{ACT_LOOKUP, 32'h1234_5678, 32'h0000_0000, 8'd1, 1'b1,
      '{32'h5A5A_5A5A, 1'b1, 7'd2, STAT_OK}},
    '{3'd5,       32'hFFFF_FFFF, 32'h0000_0000, 8'd1, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, 7'd2, STAT_OK}},
    '{3'd7,       32'h0000_0000, 32'hFFFF_FFFF, 8'd1, 1'b1, '{32'h0, 1'b0, 7'd2, STAT_OK}},
    '{3'd6,       32'h1234_5678, 32'hFFFF_FFFF, 8'd1, 1'b1,
      '{32'h5A5A_5A5A, 1'b1, 7'd2, STAT_OK}},
    '{ACT_CLEAR,  32'h1234_5678, 32'h0000_0000, 8'd1, 1'b1, '{32'h0, 1'b1, 7'd0, STAT_OK}},
    '{ACT_LOOKUP, 32'h1234_5678, 32'h0000_0000, 8'd1, 1'b1, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_REMOVE, 32'h1234_5678, 32'h0000_0000, 8'd1, 1'b1,
      '{32'h0, 1'b0, 7'd0, STAT_MISSING}},
    // Fill the table to capacity with consecutive keys.
    '{ACT_WRITE,  32'h8000_0000, 32'h0000_0001, 8'd64, 1'b0, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_ACCESS, 32'hDEAD_BEEF, 32'h0000_0000, 8'd1, 1'b1,
      '{32'h0, 1'b0, 7'd64, STAT_FULL}},
    '{ACT_WRITE,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b1,
      '{32'h0, 1'b0, 7'd64, STAT_FULL}},
    '{ACT_LOOKUP, 32'h8000_003F, 32'h0000_0000, 8'd1, 1'b0, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_ACCESS, 32'h8000_0000, 32'h0000_0000, 8'd1, 1'b0, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_REMOVE, 32'h8000_0000, 32'h0000_0000, 8'd1, 1'b0, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_REMOVE, 32'h8000_003F, 32'h0000_0000, 8'd1, 1'b0, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_WRITE,  32'h7FFF_FFFF, 32'h0000_0000, 8'd1, 1'b0, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_LOOKUP, 32'h8000_0020, 32'h0000_0000, 8'd1, 1'b0, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_CLEAR,  32'h0000_0000, 32'h0000_0000, 8'd1, 1'b0, '{32'h0, 1'b0, 7'd0, STAT_OK}},
    '{ACT_ACCESS, 32'h0000_0000, 32'h0000_0000, 8'd1, 1'b1, '{32'h0, 1'b0, 7'd1, STAT_OK}},
    '{ACT_REMOVE, 32'h0000_0000, 32'h0000_0000, 8'd1, 1'b1, '{32'h0, 1'b1, 7'd0, STAT_OK}}
  };

  linear_key_value_table_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_valid),
    .in_ready_o   (req_ready),
    .action_i     (req_action),
    .key_i        (req_key),
    .new_value_i  (req_value),
    .out_valid_o  (rsp_valid),
    .out_ready_i  (rsp_ready),
    .read_value_o (rsp_value),
    .found_o      (rsp_found),
    .entry_count_o(rsp_count),
    .status_o     (rsp_status)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Applies one request to the shadow table and returns what the block owes.
  function automatic kv_result_t apply_to_table(logic [ActionWidth-1:0] act,
                                                logic [KeyPortW-1:0] key,
                                                logic [ValuePortW-1:0] val);
    kv_result_t  res;
    bit          hit;
    int unsigned pos;
    res.read_value  = '0;
    res.status      = STAT_OK;
    hit = 1'b0;
    pos = 0;
    for (int unsigned i = 0; i < tbl_fill; i++) begin
      if (!hit && tbl_keys[i] == key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    case (act)
      ACT_ACCESS, ACT_WRITE: begin
        if (!hit && tbl_fill == Capacity) begin
          res.status = STAT_FULL;
        end else begin
          if (!hit) begin
            pos           = tbl_fill;
            tbl_keys[pos] = key;
            tbl_vals[pos] = '0;
            tbl_fill++;
          end
          if (act == ACT_WRITE) tbl_vals[pos] = val;
          res.read_value = tbl_vals[pos];
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          for (int unsigned j = pos; j + 1 < tbl_fill; j++) begin
            tbl_keys[j] = tbl_keys[j + 1];
            tbl_vals[j] = tbl_vals[j + 1];
          end
          tbl_fill--;
        end else begin
          res.status = STAT_MISSING;
        end
      end
      ACT_CLEAR: tbl_fill = 0;
      // Lookup, and the unused codes, which behave as a lookup.
      default: if (hit) res.read_value = tbl_vals[pos];
    endcase
    res.found       = hit;
    res.entry_count = CountPortW'(tbl_fill);
    return res;
  endfunction

  task automatic send_request(input logic [ActionWidth-1:0] act,
                              input logic [KeyPortW-1:0] key,
                              input logic [ValuePortW-1:0] val,
                              input logic typed,
                              input kv_result_t want);
    kv_result_t predicted;
    kv_result_t expected;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      req_valid <= 1'b0;
    end
    @(negedge clk_i);
    req_valid  <= 1'b1;
    req_action <= act;
    req_key    <= key;
    req_value  <= val;
    do @(posedge clk_i); while (req_ready !== 1'b1);
    predicted = apply_to_table(act, key, val);
    expected  = typed ? want : predicted;
    pending_results = {pending_results, expected};
    requests_sent++;
  endtask

  // Random requests in episodes. Each episode draws keys from a pool whose
  // size decides whether the table stays sparse, churns or runs full.
  task automatic run_episodes(input int unsigned stop_at);
    int unsigned            pool_size;
    int unsigned            remove_pct;
    int unsigned            ep_len;
    int unsigned            pick;
    logic [KeyPortW-1:0]    pool_base;
    logic [KeyPortW-1:0]    pool_stride;
    logic [KeyPortW-1:0]    key;
    logic [ValuePortW-1:0]  val;
    logic [ActionWidth-1:0] act;
    pool_base   = $urandom;
    pool_stride = $urandom | 32'd1;
    while (requests_sent < stop_at) begin
      if ($urandom_range(1) == 0) begin
        pool_base   = $urandom;
        pool_stride = $urandom | 32'd1;
      end
      case ($urandom_range(3))
        0:       pool_size = $urandom_range(1, 6);
        1:       pool_size = $urandom_range(8, 24);
        2:       pool_size = $urandom_range(56, 72);
        default: pool_size = $urandom_range(72, 120);
      endcase
      remove_pct = $urandom_range(5, 35);
      ep_len     = $urandom_range(20, 60);
      if ($urandom_range(3) == 0) send_request(ACT_CLEAR, $urandom, $urandom, 1'b0, '0);
      for (int unsigned n = 0; n < ep_len && requests_sent < stop_at; n++) begin
        case ($urandom_range(9))
          0:       val = '0;
          1:       val = '1;
          default: val = $urandom;
        endcase
        if ($urandom_range(99) < 8) begin
          // Noise: any action code, including the unused ones, on a random key.
          act = ActionWidth'($urandom_range(7));
          key = $urandom;
        end else begin
          key  = pool_base + pool_stride * KeyPortW'($urandom_range(pool_size - 1));
          pick = $urandom_range(99);
          if (pick < remove_pct)           act = ACT_REMOVE;
          else if (pick < remove_pct + 15) act = ACT_LOOKUP;
          else if (pick[0])                act = ACT_WRITE;
          else                             act = ACT_ACCESS;
        end
        send_request(act, key, val, 1'b0, '0);
      end
    end
  endtask

  initial begin : response_ready_drive
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        // Long back-pressure so the block fills up and stalls its input.
        rx_hold_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (RxHoldCycles) @(negedge clk_i);
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    kv_result_t want;
    if (rst_ni && rsp_valid === 1'b1 && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with none pending, value %h count %0d",
                 $time, rsp_value, rsp_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_value !== want.read_value) begin
          $display("%0t: read_value expected %h, got %h", $time, want.read_value, rsp_value);
          mismatch_count++;
        end
        if (rsp_found !== want.found) begin
          $display("%0t: found expected %b, got %b", $time, want.found, rsp_found);
          mismatch_count++;
        end
        if (rsp_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                   rsp_count);
          mismatch_count++;
        end
        if (rsp_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 23;
    rx_idle_pct = 75;
    for (int i = 0; i < NumDirRows; i++) begin
      for (int unsigned n = 0; n < dir_rows[i].reps; n++) begin
        send_request(dir_rows[i].act, dir_rows[i].key + n, dir_rows[i].value + n,
                     dir_rows[i].typed, dir_rows[i].want);
      end
    end
    run_episodes(450);

    tx_idle_pct = 75;
    rx_idle_pct = 23;
    run_episodes(800);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    run_episodes(ItemsTotal);

    @(negedge clk_i);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
